[hdl/ratclk_pkg.sv]
// Shared types, constants and helper functions of the ratio clock generator.
package ratclk_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int MAX_DURATION  = 8;
    localparam int MAX_SYNC_MULT = 48;

    localparam int PERIOD_W   = 28;
    localparam int DUR_W      = 4;
    localparam int MULT_W     = 6;
    localparam int GUARD_W    = 10;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int PHASE_W    = 32;
    localparam int PL_W       = 9;
    localparam int PROD_W     = PHASE_W + PERIOD_W;
    localparam int NUM_CLK    = 3;

    localparam int IN_W       = 4;
    localparam int OUT_W      = 6;
    localparam int TDATA_W    = 8;

    localparam int CFG_FIFO_AW    = 4;
    localparam int CFG_FIFO_DEPTH = 2 ** CFG_FIFO_AW;

    localparam logic [PHASE_W-1:0]  ONE_TICK   = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(1) << FRAC_BITS;

    // reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] RST_MASTER_PERIOD = 28'd6144000;
    localparam logic [DUR_W-1:0]    RST_MAIN_DUR      = 4'd1;
    localparam logic [DUR_W-1:0]    RST_TWIN_DUR      = 4'd1;
    localparam logic [MULT_W-1:0]   RST_SYNC_MULT     = 6'd48;
    localparam logic [GUARD_W-1:0]  RST_GUARD         = 10'd24;
    localparam logic                RST_IDLE_HIGH     = 1'b1;
    localparam logic [MASK_W-1:0]   RST_SS_MASK       = 4'd0;
    localparam logic                RST_MOMENTARY     = 1'b1;

    // start/stop mask bit positions
    localparam int MASK_STOP_RST    = 0;
    localparam int MASK_START_RST   = 1;
    localparam int MASK_STOP_PULSE  = 2;
    localparam int MASK_START_PULSE = 3;

    // input beat bit positions
    localparam int IN_RESET_EDGE = 0;
    localparam int IN_RUN_BUTTON = 1;
    localparam int IN_RUN_RISE   = 2;
    localparam int IN_RUN_FALL   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASTER_PERIOD = 3'd0,
        REG_MAIN_DUR      = 3'd1,
        REG_TWIN_DUR      = 3'd2,
        REG_SYNC_MULT     = 3'd3,
        REG_GUARD         = 3'd4,
        REG_IDLE_HIGH     = 3'd5,
        REG_SS_MASK       = 3'd6,
        REG_MOMENTARY     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_entry;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] v);
        return (v < MIN_PERIOD) ? MIN_PERIOD : v;
    endfunction

    function automatic logic [DUR_W-1:0] sat_dur(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) :
               (v > DUR_W'(MAX_DURATION)) ? DUR_W'(MAX_DURATION) : v;
    endfunction

    function automatic logic [MULT_W-1:0] sat_mult(input logic [MULT_W-1:0] v);
        return (v == '0) ? MULT_W'(1) :
               (v > MULT_W'(MAX_SYNC_MULT)) ? MULT_W'(MAX_SYNC_MULT) : v;
    endfunction

endpackage

[hdl/ratclk_cfg_fifo.sv]
// Queue of configuration writes, applied in order by the sequencer.
module ratclk_cfg_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  ratclk_pkg::t_cfg_entry i_entry,
    input  logic                   i_pop,
    output logic                   o_empty,
    output ratclk_pkg::t_cfg_entry o_head
);
    import ratclk_pkg::*;

    t_cfg_entry             r_mem [CFG_FIFO_DEPTH];
    logic [CFG_FIFO_AW:0]   r_wr_ptr;
    logic [CFG_FIFO_AW:0]   r_rd_ptr;
    logic                   full;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign full    = (r_wr_ptr[CFG_FIFO_AW] != r_rd_ptr[CFG_FIFO_AW]) &&
                     (r_wr_ptr[CFG_FIFO_AW-1:0] == r_rd_ptr[CFG_FIFO_AW-1:0]);
    assign o_head  = r_mem[r_rd_ptr[CFG_FIFO_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_we && !full) begin
            r_mem[r_wr_ptr[CFG_FIFO_AW-1:0]] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_we && !full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[hdl/ratclk_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module ratclk_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ratclk_pkg::PROD_W-1:0]     i_dividend,
    input  logic [ratclk_pkg::PERIOD_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [ratclk_pkg::PHASE_W-1:0]    o_quotient
);
    import ratclk_pkg::*;

    localparam int CNT_W = $clog2(PHASE_W + 1);

    logic [PERIOD_W:0]   r_rem;
    logic [PERIOD_W-1:0] r_div;
    logic [PHASE_W-1:0]  r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;

    logic [PERIOD_W:0]   trial;
    logic                fits;

    assign trial      = {r_rem[PERIOD_W-1:0], r_quo[PHASE_W-1]};
    assign fits       = (trial >= {1'b0, r_div});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper part stays below the divisor, so the quotient fits PHASE_W bits
            r_rem <= {1'b0, i_dividend[PROD_W-1:PHASE_W]};
            r_quo <= i_dividend[PHASE_W-1:0];
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[PHASE_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(PHASE_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divider done held longer than one cycle");

endmodule

[hdl/ratio_clock_generator_top.sv]
// Ratio clock generator: run control, three phase accumulators and sequencer.
//
//  channel  | direction | signals                       | beat contents (low bit up)
//  ---------+-----------+-------------------------------+--------------------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata[7:0] | reset_edge, run_button_edge,
//           |           |                               | run_in_rise, run_in_fall, pad
//  m_axis   | out       | m_axis_tvalid/tready/tdata[7:0] | twin_one_level, twin_two_level,
//           |           |                               | sync_level, reset_event,
//           |           |                               | run_event, is_running, pad
//  cfg      | in        | i_cfg_we, i_cfg_addr, i_cfg_wdata | register write, no read-back
//
// Each twin or sync restart in a running tick goes through the shared 32-step
// divider; a stopped tick goes straight to the output step. A master_period write
// that changes the period rescales up to six values (the three lengths and the
// phases of active clocks) through the same divider before the next beat is taken.
// Config writes queue in a 16-entry FIFO, one applied per cycle while idle.
// Reset is synchronous and needs no clearing pass; a result waiting on m_axis
// stalls only the last step of the following beat.
module ratio_clock_generator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // reset_edge, run_button_edge, run_in_rise, run_in_fall, zero pad
    input  logic [ratclk_pkg::TDATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // twin_one_level, twin_two_level, sync_level, reset_event, run_event,
    // is_running, zero pad
    output logic [ratclk_pkg::TDATA_W-1:0]        m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [ratclk_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [ratclk_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import ratclk_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SMUL   = 13'b0000000000010,
        ST_SDGO   = 13'b0000000000100,
        ST_SWAIT  = 13'b0000000001000,
        ST_RUN    = 13'b0000000010000,
        ST_MSTART = 13'b0000000100000,
        ST_TSTART = 13'b0000001000000,
        ST_TWAIT  = 13'b0000010000000,
        ST_YSTART = 13'b0000100000000,
        ST_YWAIT  = 13'b0001000000000,
        ST_YLVL   = 13'b0010000000000,
        ST_ADV    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } t_state;

    localparam logic [2:0] SCALE_LAST = 3'd5;
    localparam logic [1:0] ADV_LAST   = 2'd2;

    // ---- registers ----
    t_state               r_state,  n_state;
    logic [PERIOD_W-1:0]  r_master_period, n_master_period;
    logic [DUR_W-1:0]     r_main_dur, n_main_dur;
    logic [DUR_W-1:0]     r_twin_dur, n_twin_dur;
    logic [MULT_W-1:0]    r_sync_mult, n_sync_mult;
    logic [GUARD_W-1:0]   r_guard, n_guard;
    logic                 r_idle_high, n_idle_high;
    logic [MASK_W-1:0]    r_ss_mask, n_ss_mask;
    logic                 r_momentary, n_momentary;

    logic                 r_running, n_running;
    logic [NUM_CLK-1:0]   r_act, n_act;
    logic [PHASE_W-1:0]   r_phase [NUM_CLK];
    logic [PHASE_W-1:0]   n_phase [NUM_CLK];
    logic [PHASE_W-1:0]   r_len [NUM_CLK];
    logic [PHASE_W-1:0]   n_len [NUM_CLK];
    logic [PL_W-1:0]      r_pl [NUM_CLK];
    logic [PL_W-1:0]      n_pl [NUM_CLK];
    logic [PHASE_W-1:0]   r_carry, n_carry;
    logic [NUM_CLK-1:0]   r_held, n_held;
    logic [DUR_W-1:0]     r_lat_main, n_lat_main;
    logic [DUR_W-1:0]     r_lat_twin, n_lat_twin;
    logic                 r_pending, n_pending;
    logic                 r_reset_req, n_reset_req;
    logic                 r_run_ev, n_run_ev;
    logic [IN_W-1:0]      r_in, n_in;
    logic [1:0]           r_idx, n_idx;
    logic [2:0]           r_sidx, n_sidx;
    logic [PERIOD_W-1:0]  r_old_period, n_old_period;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_data, n_out_data;

    // ---- config queue ----
    t_cfg_entry           cfg_in;
    t_cfg_entry           cfg_head;
    logic                 cfg_empty;
    logic                 cfg_pop;

    assign cfg_in.index = i_cfg_addr;
    assign cfg_in.value = i_cfg_wdata;

    ratclk_cfg_fifo u_cfg_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_entry (cfg_in),
        .i_pop   (cfg_pop),
        .o_empty (cfg_empty),
        .o_head  (cfg_head)
    );

    // ---- shared divider ----
    logic                 div_start;
    logic [PROD_W-1:0]    div_dividend;
    logic [PERIOD_W-1:0]  div_divisor;
    logic                 div_done;
    logic [PHASE_W-1:0]   div_quot;

    ratclk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // ---- datapath helpers ----
    logic [PERIOD_W-1:0]        eff_m;
    logic [MULT_W-1:0]          mult_eff;
    logic [PERIOD_W+DUR_W-1:0]  twin_num;
    logic [MULT_W+DUR_W-1:0]    sync_cnt;
    logic [1:0]                 sc_k;
    logic                       sc_is_len;
    logic [PHASE_W-1:0]         scale_op;
    logic [PROD_W-1:0]          scale_prod;
    logic [NUM_CLK-1:0]         lvl;

    assign eff_m      = eff_period(r_master_period);
    assign mult_eff   = sat_mult(r_sync_mult);
    assign twin_num   = eff_m * r_lat_main;
    assign sync_cnt   = mult_eff * r_lat_main;
    assign sc_k       = r_sidx[2:1];
    assign sc_is_len  = r_sidx[0];
    assign scale_op   = sc_is_len ? r_len[sc_k] : r_phase[sc_k];
    assign scale_prod = scale_op * eff_m;

    always_comb begin
        for (int k = 0; k < NUM_CLK; k++) begin
            lvl[k] = ({r_phase[k], 1'b0} < {1'b0, r_len[k]});
        end
    end

    // advance unit, shared over the master, twin and sync clocks
    logic [PHASE_W-1:0]          adv_ph;
    logic [PHASE_W-1:0]          adv_len;
    logic [PL_W-1:0]             adv_pl;
    logic [PHASE_W:0]            adv_p;
    logic [PHASE_W:0]            adv_sub;
    logic [GUARD_W+FRAC_BITS-1:0] guard_fx;
    logic                        adv_hold;
    logic                        adv_wrap;

    assign adv_ph   = r_phase[r_idx];
    assign adv_len  = r_len[r_idx];
    assign adv_pl   = r_pl[r_idx];
    assign adv_p    = {1'b0, adv_ph} + {1'b0, ONE_TICK};
    assign adv_sub  = adv_p - {1'b0, adv_len};
    assign guard_fx = {r_guard, {FRAC_BITS{1'b0}}};
    assign adv_hold = (r_idx != 2'd0) && (adv_pl == PL_W'(1)) &&
                      (({1'b0, adv_p} + (PHASE_W+2)'(guard_fx)) > {2'b0, adv_len});
    assign adv_wrap = (adv_p >= {1'b0, adv_len});

    // run control
    logic btn, rise, fall, rst_in;
    logic run1, tog2, run2, irst, rreq;

    assign rst_in = r_in[IN_RESET_EDGE];
    assign btn    = r_in[IN_RUN_BUTTON];
    assign rise   = r_in[IN_RUN_RISE];
    assign fall   = r_in[IN_RUN_FALL];
    assign run1   = r_running ^ btn;
    assign tog2   = r_momentary ? rise : ((run1 && fall) || (!run1 && rise));
    assign run2   = run1 ^ tog2;
    assign irst   = rst_in ||
        (btn  && (run1 ? r_ss_mask[MASK_START_RST] : r_ss_mask[MASK_STOP_RST])) ||
        (tog2 && (run2 ? r_ss_mask[MASK_START_RST] : r_ss_mask[MASK_STOP_RST]));
    assign rreq   = rst_in ||
        (btn  && (run1 ? r_ss_mask[MASK_START_PULSE] : r_ss_mask[MASK_STOP_PULSE])) ||
        (tog2 && (run2 ? r_ss_mask[MASK_START_PULSE] : r_ss_mask[MASK_STOP_PULSE]));

    assign s_axis_tready = (r_state == ST_IDLE) && cfg_empty;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);

    // ---- sequencer ----
    logic int_rst;
    logic [DUR_W-1:0] lat_main_use;

    assign lat_main_use = r_pending ? sat_dur(r_main_dur) : r_lat_main;

    always_comb begin
        n_state         = r_state;
        n_master_period = r_master_period;
        n_main_dur      = r_main_dur;
        n_twin_dur      = r_twin_dur;
        n_sync_mult     = r_sync_mult;
        n_guard         = r_guard;
        n_idle_high     = r_idle_high;
        n_ss_mask       = r_ss_mask;
        n_momentary     = r_momentary;
        n_running       = r_running;
        n_act           = r_act;
        n_phase         = r_phase;
        n_len           = r_len;
        n_pl            = r_pl;
        n_carry         = r_carry;
        n_held          = r_held;
        n_lat_main      = r_lat_main;
        n_lat_twin      = r_lat_twin;
        n_pending       = r_pending;
        n_reset_req     = r_reset_req;
        n_run_ev        = r_run_ev;
        n_in            = r_in;
        n_idx           = r_idx;
        n_sidx          = r_sidx;
        n_old_period    = r_old_period;
        n_prod          = r_prod;
        n_out_valid     = r_out_valid && !m_axis_tready;
        n_out_data      = r_out_data;
        int_rst         = 1'b0;
        cfg_pop         = 1'b0;
        div_start       = 1'b0;
        div_dividend    = PROD_W'(eff_m);
        div_divisor     = r_old_period;

        case (r_state)
            ST_IDLE: begin
                if (!cfg_empty) begin
                    cfg_pop = 1'b1;
                    case (t_reg_idx'(cfg_head.index))
                        REG_MASTER_PERIOD: begin
                            n_master_period = cfg_head.value[PERIOD_W-1:0];
                            if (eff_period(cfg_head.value[PERIOD_W-1:0]) != eff_m) begin
                                n_old_period = eff_m;
                                n_sidx       = '0;
                                n_state      = ST_SMUL;
                            end
                        end
                        REG_MAIN_DUR: begin
                            if (cfg_head.value[DUR_W-1:0] != r_main_dur) n_pending = 1'b1;
                            n_main_dur = cfg_head.value[DUR_W-1:0];
                        end
                        REG_TWIN_DUR: begin
                            if (cfg_head.value[DUR_W-1:0] != r_twin_dur) n_pending = 1'b1;
                            n_twin_dur = cfg_head.value[DUR_W-1:0];
                        end
                        REG_SYNC_MULT: n_sync_mult = cfg_head.value[MULT_W-1:0];
                        REG_GUARD:     n_guard     = cfg_head.value[GUARD_W-1:0];
                        REG_IDLE_HIGH: begin
                            if (cfg_head.value[0] != r_idle_high) begin
                                n_idle_high = cfg_head.value[0];
                                int_rst     = 1'b1;
                            end
                        end
                        REG_SS_MASK:   n_ss_mask   = cfg_head.value[MASK_W-1:0];
                        REG_MOMENTARY: n_momentary = cfg_head.value[0];
                        default: ;
                    endcase
                end else if (s_axis_tvalid) begin
                    n_in    = s_axis_tdata[IN_W-1:0];
                    n_state = ST_RUN;
                end
            end

            // rescale phase (active clocks only) and length by new/old period
            ST_SMUL: begin
                if (!sc_is_len && !r_act[sc_k]) begin
                    n_sidx = r_sidx + 1'b1;
                end else begin
                    n_prod  = scale_prod;
                    n_state = ST_SDGO;
                end
            end

            ST_SDGO: begin
                div_start    = 1'b1;
                div_dividend = r_prod;
                div_divisor  = r_old_period;
                n_state      = ST_SWAIT;
            end

            ST_SWAIT: begin
                if (div_done) begin
                    if (sc_is_len) begin
                        n_len[sc_k] = div_quot;
                    end else begin
                        n_phase[sc_k] = div_quot;
                    end
                    if (r_sidx == SCALE_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_sidx  = r_sidx + 1'b1;
                        n_state = ST_SMUL;
                    end
                end
            end

            ST_RUN: begin
                n_running   = run2;
                n_run_ev    = btn || tog2;
                n_reset_req = rreq;
                int_rst     = irst;
                n_state     = run2 ? ST_MSTART : ST_OUT;
            end

            ST_MSTART: begin
                if (!r_act[0]) begin
                    if (r_pending) begin
                        n_act[1]   = 1'b0;
                        n_act[2]   = 1'b0;
                        n_lat_main = sat_dur(r_main_dur);
                        n_lat_twin = sat_dur(r_twin_dur);
                        n_pending  = 1'b0;
                    end
                    n_len[0]   = PHASE_W'(eff_m);
                    n_pl[0]    = PL_W'(lat_main_use);
                    n_phase[0] = r_carry;
                    n_act[0]   = 1'b1;
                end
                n_state = ST_TSTART;
            end

            ST_TSTART: begin
                n_held[0] = lvl[0];
                if (r_act[1]) begin
                    n_state = ST_YSTART;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = PROD_W'(twin_num);
                    div_divisor  = PERIOD_W'(r_lat_twin);
                    n_state      = ST_TWAIT;
                end
            end

            ST_TWAIT: begin
                if (div_done) begin
                    n_len[1]   = div_quot;
                    n_pl[1]    = PL_W'(r_lat_twin);
                    n_phase[1] = '0;
                    n_act[1]   = 1'b1;
                    n_state    = ST_YSTART;
                end
            end

            ST_YSTART: begin
                n_held[1] = lvl[1];
                if (r_act[2]) begin
                    n_state = ST_YLVL;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = PROD_W'(eff_m);
                    div_divisor  = PERIOD_W'(mult_eff);
                    n_state      = ST_YWAIT;
                end
            end

            ST_YWAIT: begin
                if (div_done) begin
                    n_len[2]   = div_quot;
                    n_pl[2]    = PL_W'(sync_cnt);
                    n_phase[2] = '0;
                    n_act[2]   = 1'b1;
                    n_state    = ST_YLVL;
                end
            end

            ST_YLVL: begin
                n_held[2] = lvl[2];
                n_idx     = '0;
                n_state   = ST_ADV;
            end

            // master first, then twin and sync, which look at the master's new state
            ST_ADV: begin
                if (r_act[r_idx]) begin
                    if (adv_hold) begin
                        n_phase[r_idx] = adv_p[PHASE_W-1:0];
                        if (!r_act[0]) n_act[r_idx] = 1'b0;
                    end else if (adv_wrap) begin
                        n_phase[r_idx] = adv_sub[PHASE_W-1:0];
                        if (adv_pl <= PL_W'(1)) begin
                            n_pl[r_idx]  = '0;
                            n_act[r_idx] = 1'b0;
                            if (r_idx == 2'd0) n_carry = adv_sub[PHASE_W-1:0];
                        end else begin
                            n_pl[r_idx] = adv_pl - 1'b1;
                        end
                    end else begin
                        n_phase[r_idx] = adv_p[PHASE_W-1:0];
                    end
                end
                if (r_idx == ADV_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_running, r_run_ev, r_reset_req, r_held};
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (int_rst) begin
            n_act      = '0;
            n_held     = {NUM_CLK{n_idle_high}};
            n_carry    = '0;
            n_lat_main = sat_dur(n_main_dur);
            n_lat_twin = sat_dur(n_twin_dur);
            n_pending  = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        n_prod_hold: begin
            r_prod       <= n_prod;
            r_old_period <= n_old_period;
            r_in         <= n_in;
            r_out_data   <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_master_period <= RST_MASTER_PERIOD;
            r_main_dur      <= RST_MAIN_DUR;
            r_twin_dur      <= RST_TWIN_DUR;
            r_sync_mult     <= RST_SYNC_MULT;
            r_guard         <= RST_GUARD;
            r_idle_high     <= RST_IDLE_HIGH;
            r_ss_mask       <= RST_SS_MASK;
            r_momentary     <= RST_MOMENTARY;
            r_running       <= 1'b1;
            r_act           <= '0;
            r_phase         <= '{default: '0};
            r_len           <= '{default: '0};
            r_pl            <= '{default: '0};
            r_carry         <= '0;
            r_held          <= {NUM_CLK{RST_IDLE_HIGH}};
            r_lat_main      <= sat_dur(RST_MAIN_DUR);
            r_lat_twin      <= sat_dur(RST_TWIN_DUR);
            r_pending       <= 1'b0;
            r_reset_req     <= 1'b0;
            r_run_ev        <= 1'b0;
            r_idx           <= '0;
            r_sidx          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_master_period <= n_master_period;
            r_main_dur      <= n_main_dur;
            r_twin_dur      <= n_twin_dur;
            r_sync_mult     <= n_sync_mult;
            r_guard         <= n_guard;
            r_idle_high     <= n_idle_high;
            r_ss_mask       <= n_ss_mask;
            r_momentary     <= n_momentary;
            r_running       <= n_running;
            r_act           <= n_act;
            r_phase         <= n_phase;
            r_len           <= n_len;
            r_pl            <= n_pl;
            r_carry         <= n_carry;
            r_held          <= n_held;
            r_lat_main      <= n_lat_main;
            r_lat_twin      <= n_lat_twin;
            r_pending       <= n_pending;
            r_reset_req     <= n_reset_req;
            r_run_ev        <= n_run_ev;
            r_idx           <= n_idx;
            r_sidx          <= n_sidx;
            r_out_valid     <= n_out_valid;
        end
    end

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second beat taken while a tick is in progress");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT))
        else $error("result presented outside the output step");

    a_master_periods: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act[0] |-> (r_pl[0] != '0))
        else $error("active master clock with no periods left");

    a_sub_periods: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_act[1] && (r_pl[1] == '0)) && !(r_act[2] && (r_pl[2] == '0)))
        else $error("active sub clock with no periods left");

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lat_main != '0) && (r_lat_twin != '0) &&
        (r_lat_main <= DUR_W'(MAX_DURATION)) && (r_lat_twin <= DUR_W'(MAX_DURATION)))
        else $error("latched duration out of range");

endmodule
